// ----- hdl/ctpc_pkg.sv -----
// shared types, constants and field packing for the climate threshold controller
// no dependencies; used by every file of the block

package ctpc_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CMD_W     = 3;
  localparam int NOW_W     = 32;
  localparam int READ_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int TLIM_W    = 6;
  localparam int HLIM_W    = 7;
  localparam int PCT_W     = 7;
  localparam int DUTY_W    = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // divider operands: diff (7 bits) times a 16 bit scale, over a 7 bit divisor
  localparam int DIV_N_W = HLIM_W + DUTY_W;
  localparam int DIV_D_W = HLIM_W;

  localparam logic [TLIM_W-1:0] TEMP_MAX     = 6'd60;
  localparam logic [TLIM_W-1:0] TEMP_RST     = 6'd20;
  localparam logic [HLIM_W-1:0] HUMI_MAX     = 7'd100;
  localparam logic [HLIM_W-1:0] HUMI_RST     = 7'd60;
  localparam logic [DUTY_W-1:0] PCT_SCALE    = 16'd100;
  localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 16'd200;
  localparam logic [CFG_W-1:0]  FSCALE_RST   = 16'd65535;

  typedef enum logic [CMD_W-1:0] {
    CMD_MODE  = 3'd0,
    CMD_UP    = 3'd1,
    CMD_DOWN  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_FAULT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_TEMP   = 2'd1,
    MODE_HUMI   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 1'd0,
    REG_FULL_SCALE = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_HEAT,
    OP_FAN,
    OP_PCT
  } op_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [NOW_W-1:0]         now_ms;
    logic signed [READ_W-1:0] temp_reading;
    logic [READ_W-1:0]        humi_reading;
  } item_t;

  typedef struct packed {
    logic              key_accepted;
    logic [1:0]        mode;
    logic [TLIM_W-1:0] temp_limit;
    logic [HLIM_W-1:0] humi_limit;
    logic [DUTY_W-1:0] heater_duty;
    logic [DUTY_W-1:0] fan_duty;
    logic [PCT_W-1:0]  fan_percent;
    logic              fan_on;
    logic              save_request;
    logic              sensor_fault;
  } result_t;

  function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
    return {6'd0, r.sensor_fault, r.save_request, r.fan_on, r.fan_percent, r.fan_duty,
            r.heater_duty, r.humi_limit, r.temp_limit, r.mode, r.key_accepted};
  endfunction

endpackage

// ----- hdl/ctpc_div.sv -----
// restoring divider, one quotient bit per cycle, shared by all duty computations
// depends on ctpc_pkg for operand widths

module ctpc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ctpc_pkg::DIV_N_W-1:0]   dividend,
  input  logic [ctpc_pkg::DIV_D_W-1:0]   divisor,
  output logic                           done,
  output logic [ctpc_pkg::DUTY_W-1:0]    quotient
);

  localparam int N_W   = ctpc_pkg::DIV_N_W;
  localparam int D_W   = ctpc_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsr;
  logic [N_W-1:0]   quo;
  logic [D_W:0]     shifted;
  logic [D_W:0]     diff;
  logic             fits;
  logic [D_W-1:0]   rem_next;

  always_comb begin
    shifted  = {rem, quo[N_W-1]};
    fits     = shifted >= {1'b0, dsr};
    diff     = shifted - {1'b0, dsr};
    rem_next = fits ? diff[D_W-1:0] : shifted[D_W-1:0];
  end

  assign done     = busy && (cnt == '0);
  assign quotient = quo[ctpc_pkg::DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N_W);
      rem  <= '0;
      quo  <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        rem <= rem_next;
        quo <= {quo[N_W-2:0], fits};
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ctpc_core.sv -----
// menu, debounce and duty sequencer; drives the shared divider up to three times per reading
// depends on ctpc_pkg and ctpc_div

module ctpc_core #(
  parameter int TIME_BITS = ctpc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  ctpc_pkg::item_t               item,
  input  logic [ctpc_pkg::CFG_W-1:0]    debounce_ms,
  input  logic [ctpc_pkg::CFG_W-1:0]    duty_full_scale,
  input  logic                          out_free,
  output logic                          idle,
  output logic                          res_valid,
  output ctpc_pkg::result_t             res
);

  localparam int TL_W = ctpc_pkg::TLIM_W;
  localparam int HL_W = ctpc_pkg::HLIM_W;
  localparam int DW   = ctpc_pkg::DUTY_W;
  localparam int RW   = ctpc_pkg::READ_W;

  ctpc_pkg::state_t state, state_next;
  ctpc_pkg::op_t    op;
  ctpc_pkg::mode_t  menu_mode;

  logic [TL_W-1:0]      temp_limit;
  logic [HL_W-1:0]      humi_limit;
  logic [TIME_BITS-1:0] key_last [3];
  logic [DW-1:0]        heater_level;
  logic [DW-1:0]        fan_level;
  logic [ctpc_pkg::PCT_W-1:0] fan_pct;
  logic                 fault_flag;
  logic                 fan_on;
  logic                 key_acc;
  logic                 save;

  logic [TL_W-1:0] diff_h;
  logic            heat_on;
  logic [HL_W-1:0] diff_f;
  logic [HL_W-1:0] humi_span;
  logic [ctpc_pkg::DIV_N_W-1:0] prod;
  logic [ctpc_pkg::DIV_D_W-1:0] den;

  // item decode
  logic [TIME_BITS-1:0] now_t;
  logic [1:0]           key_idx;
  logic                 is_key;
  logic [TIME_BITS-1:0] last_sel;
  logic [TIME_BITS-1:0] elapsed;
  logic                 pass;
  logic signed [RW:0]   temp_ext;
  logic signed [RW:0]   tl_ext;
  logic signed [RW:0]   heat_raw;
  logic                 heat_cmp;
  logic [TL_W-1:0]      diff_h_c;
  logic [HL_W-1:0]      span_c;
  logic                 fan_cmp;
  logic [RW-1:0]        fan_raw;
  logic [HL_W-1:0]      diff_f_c;

  // shared unit operand selection
  logic [HL_W-1:0]              mul_a;
  logic [DW-1:0]                mul_b;
  logic [ctpc_pkg::DIV_D_W-1:0] den_c;
  logic                         op_live;
  logic [ctpc_pkg::DIV_N_W-1:0] product_c;

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_q;

  ctpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic ctpc_pkg::op_t next_op(input ctpc_pkg::op_t o);
    case (o)
      ctpc_pkg::OP_HEAT: return ctpc_pkg::OP_FAN;
      ctpc_pkg::OP_FAN:  return ctpc_pkg::OP_PCT;
      default:           return ctpc_pkg::OP_PCT;
    endcase
  endfunction

  always_comb begin
    now_t    = TIME_BITS'(item.now_ms);
    key_idx  = item.cmd[1:0];
    is_key   = (item.cmd == ctpc_pkg::CMD_MODE) || (item.cmd == ctpc_pkg::CMD_UP) ||
               (item.cmd == ctpc_pkg::CMD_DOWN);
    last_sel = is_key ? key_last[key_idx] : '0;
    elapsed  = now_t - last_sel;
    pass     = elapsed > TIME_BITS'(debounce_ms);

    temp_ext = {item.temp_reading[RW-1], item.temp_reading};
    tl_ext   = $signed({3'b000, temp_limit});
    heat_cmp = temp_ext < tl_ext;
    heat_raw = tl_ext - temp_ext;
    diff_h_c = item.temp_reading[RW-1] ? temp_limit : heat_raw[TL_W-1:0];

    span_c   = ctpc_pkg::HUMI_MAX - humi_limit;
    fan_cmp  = item.humi_reading > {1'b0, humi_limit};
    fan_raw  = item.humi_reading - {1'b0, humi_limit};
    diff_f_c = (fan_raw > {1'b0, span_c}) ? span_c : fan_raw[HL_W-1:0];
  end

  always_comb begin
    case (op)
      ctpc_pkg::OP_HEAT: begin
        mul_a   = {1'b0, diff_h};
        mul_b   = duty_full_scale;
        den_c   = {1'b0, temp_limit};
        op_live = heat_on && (temp_limit != '0);
      end
      ctpc_pkg::OP_FAN: begin
        mul_a   = diff_f;
        mul_b   = duty_full_scale;
        den_c   = humi_span;
        op_live = fan_on && (humi_span != '0);
      end
      ctpc_pkg::OP_PCT: begin
        mul_a   = diff_f;
        mul_b   = ctpc_pkg::PCT_SCALE;
        den_c   = humi_span;
        op_live = fan_on && (humi_span != '0);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        den_c   = '0;
        op_live = 1'b0;
      end
    endcase
    product_c = ctpc_pkg::DIV_N_W'(mul_a) * ctpc_pkg::DIV_N_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_valid  = 1'b0;
    case (state)
      ctpc_pkg::ST_IDLE: begin
        if (start) begin
          if (item.cmd == ctpc_pkg::CMD_READ && menu_mode == ctpc_pkg::MODE_NORMAL) begin
            state_next = ctpc_pkg::ST_MUL;
          end else begin
            state_next = ctpc_pkg::ST_DONE;
          end
        end
      end
      ctpc_pkg::ST_MUL: begin
        if (op_live) begin
          state_next = ctpc_pkg::ST_DIV_START;
        end else if (op == ctpc_pkg::OP_PCT) begin
          state_next = ctpc_pkg::ST_DONE;
        end
      end
      ctpc_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ctpc_pkg::ST_DIV_WAIT;
      end
      ctpc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (op == ctpc_pkg::OP_PCT) ? ctpc_pkg::ST_DONE : ctpc_pkg::ST_MUL;
        end
      end
      ctpc_pkg::ST_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ctpc_pkg::ST_IDLE;
        end
      end
      default: state_next = ctpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_mode    <= ctpc_pkg::MODE_NORMAL;
      temp_limit   <= ctpc_pkg::TEMP_RST;
      humi_limit   <= ctpc_pkg::HUMI_RST;
      key_last[0]  <= '0;
      key_last[1]  <= '0;
      key_last[2]  <= '0;
      heater_level <= '0;
      fan_level    <= '0;
      fan_pct      <= '0;
      fault_flag   <= 1'b0;
      fan_on       <= 1'b0;
      key_acc      <= 1'b0;
      save         <= 1'b0;
      op           <= ctpc_pkg::OP_HEAT;
    end else begin
      case (state)
        ctpc_pkg::ST_IDLE: begin
          if (start) begin
            key_acc <= is_key && pass;
            save    <= is_key && pass && (item.cmd == ctpc_pkg::CMD_MODE) &&
                       (menu_mode == ctpc_pkg::MODE_HUMI);
            op      <= ctpc_pkg::OP_HEAT;
            if (is_key) begin
              if (pass) begin
                key_last[key_idx] <= now_t;
                if (item.cmd == ctpc_pkg::CMD_MODE) begin
                  case (menu_mode)
                    ctpc_pkg::MODE_NORMAL: menu_mode <= ctpc_pkg::MODE_TEMP;
                    ctpc_pkg::MODE_TEMP:   menu_mode <= ctpc_pkg::MODE_HUMI;
                    ctpc_pkg::MODE_HUMI:   menu_mode <= ctpc_pkg::MODE_NORMAL;
                    default: menu_mode <= ctpc_pkg::MODE_NORMAL;
                  endcase
                end else if (item.cmd == ctpc_pkg::CMD_UP) begin
                  if (menu_mode == ctpc_pkg::MODE_TEMP && temp_limit < ctpc_pkg::TEMP_MAX) begin
                    temp_limit <= temp_limit + 1'b1;
                  end else if (menu_mode == ctpc_pkg::MODE_HUMI &&
                               humi_limit < ctpc_pkg::HUMI_MAX) begin
                    humi_limit <= humi_limit + 1'b1;
                  end
                end else begin
                  if (menu_mode == ctpc_pkg::MODE_TEMP && temp_limit != '0) begin
                    temp_limit <= temp_limit - 1'b1;
                  end else if (menu_mode == ctpc_pkg::MODE_HUMI && humi_limit != '0) begin
                    humi_limit <= humi_limit - 1'b1;
                  end
                end
              end
            end else if (menu_mode == ctpc_pkg::MODE_NORMAL) begin
              if (item.cmd == ctpc_pkg::CMD_READ) begin
                diff_h     <= diff_h_c;
                heat_on    <= heat_cmp;
                diff_f     <= diff_f_c;
                humi_span  <= span_c;
                fan_on     <= fan_cmp;
                fault_flag <= 1'b0;
              end else if (item.cmd == ctpc_pkg::CMD_FAULT) begin
                heater_level <= '0;
                fan_level    <= '0;
                fan_pct      <= '0;
                fan_on       <= 1'b0;
                fault_flag   <= 1'b1;
              end
            end
          end
        end
        ctpc_pkg::ST_MUL: begin
          if (op_live) begin
            prod <= product_c;
            den  <= den_c;
          end else begin
            case (op)
              ctpc_pkg::OP_HEAT: heater_level <= '0;
              ctpc_pkg::OP_FAN:  fan_level    <= '0;
              default:           fan_pct      <= '0;
            endcase
            op <= next_op(op);
          end
        end
        ctpc_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            case (op)
              ctpc_pkg::OP_HEAT: heater_level <= div_q;
              ctpc_pkg::OP_FAN:  fan_level    <= div_q;
              default:           fan_pct      <= div_q[ctpc_pkg::PCT_W-1:0];
            endcase
            op <= next_op(op);
          end
        end
        default: ;
      endcase
    end
  end

  assign idle = (state == ctpc_pkg::ST_IDLE);

  always_comb begin
    res.key_accepted = key_acc;
    res.mode         = menu_mode;
    res.temp_limit   = temp_limit;
    res.humi_limit   = humi_limit;
    res.heater_duty  = heater_level;
    res.fan_duty     = fan_level;
    res.fan_percent  = fan_pct;
    res.fan_on       = fan_on;
    res.save_request = save;
    res.sensor_fault = fault_flag;
  end

endmodule

// ----- hdl/climate_threshold_pwm_controller.sv -----
// top level: stream ports, configuration registers and the result register
// depends on ctpc_pkg and ctpc_core
//
// one input item on the s_ side gives exactly one result item on the m_ side.
// s_tuser carries the command: mode key, up key, down key, sensor reading or
// sensor fault; s_tdata carries the key timestamp and the sensor values.
// the cfg channel writes the debounce time (index 0) and the duty full scale
// (index 1); cfg_ready is always high and writes belong between items.
// a key press, a fault or an ignored reading goes from idle straight to the
// done state and moves into the output register once it is free. a reading
// in normal mode runs up to three divisions one after another on the shared
// 1 bit per cycle divider: heater duty, fan duty and fan percent; a division
// is skipped when its divisor is zero or its output is off. s_tready is low
// from acceptance until the result has moved into the output register, so
// one item is in work at a time. a stalled m_tready holds the result and its
// tdata steady; the next item is taken as soon as the sequencer is free and
// waits at the end of its work until the output register empties.
// reset puts the menu in normal mode, the limits at 20 degrees and 60
// percent, duties at zero, the key times at zero and the config at defaults.

module climate_threshold_pwm_controller #(
  parameter int TIME_BITS = ctpc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ctpc_pkg::IN_DATA_W-1:0]      s_tdata,   // now_ms, temp_reading, humi_reading
  input  logic [ctpc_pkg::CMD_W-1:0]          s_tuser,   // cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // key_accepted, mode, temp_limit, humi_limit, heater_duty, fan_duty,
  // fan_percent, fan_on, save_request, sensor_fault
  output logic [ctpc_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctpc_pkg::CFG_W-1:0]          cfg_data
);

  logic [ctpc_pkg::CFG_W-1:0] debounce_ms;
  logic [ctpc_pkg::CFG_W-1:0] duty_full_scale;

  ctpc_pkg::item_t   item;
  ctpc_pkg::result_t res;
  logic              core_idle;
  logic              res_valid;
  logic              out_free;
  logic              start;

  assign cfg_ready = 1'b1;
  assign s_tready  = core_idle;
  assign start     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    item.cmd          = ctpc_pkg::cmd_t'(s_tuser);
    item.now_ms       = s_tdata[31:0];
    item.temp_reading = s_tdata[39:32];
    item.humi_reading = s_tdata[47:40];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= ctpc_pkg::DEBOUNCE_RST;
      duty_full_scale <= ctpc_pkg::FSCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ctpc_pkg::cfg_reg_t'(cfg_index))
        ctpc_pkg::REG_DEBOUNCE:   debounce_ms     <= cfg_data;
        ctpc_pkg::REG_FULL_SCALE: duty_full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  ctpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .item            (item),
    .debounce_ms     (debounce_ms),
    .duty_full_scale (duty_full_scale),
    .out_free        (out_free),
    .idle            (core_idle),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= ctpc_pkg::pack_result(res);
    end
  end

endmodule

// ----- hdl/ctpc_checker.sv -----
// port level checks for the climate threshold controller, bound to the top level
// depends on climate_threshold_pwm_controller and ctpc_pkg

module ctpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ctpc_pkg::OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:1] == ctpc_pkg::MODE_NORMAL ||
                 m_tdata[2:1] == ctpc_pkg::MODE_TEMP ||
                 m_tdata[2:1] == ctpc_pkg::MODE_HUMI)
    else $error("unreachable menu mode shown");

  // save only on an accepted key with the menu back in normal mode
  a_save: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[56] |-> m_tdata[0] && m_tdata[2:1] == ctpc_pkg::MODE_NORMAL)
    else $error("save request without return to normal");

  // a fault keeps every drive value at zero
  a_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[57] |-> m_tdata[31:16] == 16'd0 && m_tdata[47:32] == 16'd0 &&
                                m_tdata[54:48] == 7'd0 && !m_tdata[55])
    else $error("drive active during sensor fault");

endmodule

bind climate_threshold_pwm_controller ctpc_checker u_ctpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/climate_threshold_pwm_controller_tb.sv -----
// self-checking bench for climate_threshold_pwm_controller: directed and random
// key, reading and fault items under several config settings and idle patterns
// depends on ctpc_pkg and the block's rtl only

`timescale 1ns / 100ps

module climate_threshold_pwm_controller_tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 135;
  localparam int FIELD_CNT   = 11;

  localparam int CFG_W      = ctpc_pkg::CFG_W;
  localparam int CFG_IDX_W  = ctpc_pkg::CFG_IDX_W;
  localparam int CMD_W      = ctpc_pkg::CMD_W;
  localparam int NOW_W      = ctpc_pkg::NOW_W;
  localparam int READ_W     = ctpc_pkg::READ_W;
  localparam int TLIM_W     = ctpc_pkg::TLIM_W;
  localparam int HLIM_W     = ctpc_pkg::HLIM_W;
  localparam int PCT_W      = ctpc_pkg::PCT_W;
  localparam int DUTY_W     = ctpc_pkg::DUTY_W;
  localparam int IN_DATA_W  = ctpc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ctpc_pkg::OUT_DATA_W;

  class climate_result_board;
    logic [CFG_W-1:0]  debounce;
    logic [CFG_W-1:0]  full_scale;
    ctpc_pkg::mode_t   menu;
    logic [TLIM_W-1:0] tlim;
    logic [HLIM_W-1:0] hlim;
    logic [NOW_W-1:0]  last_press[3];
    logic [DUTY_W-1:0] heat;
    logic [DUTY_W-1:0] fan;
    logic [PCT_W-1:0]  pct;
    logic              fan_running;
    logic              faulted;
    ctpc_pkg::result_t pending_results[$];
    int                errors;
    int                seen;
    string             field_name[FIELD_CNT] = '{"key_accepted", "mode", "temp_limit",
                                                  "humi_limit", "heater_duty", "fan_duty",
                                                  "fan_percent", "fan_on", "save_request",
                                                  "sensor_fault", "padding"};

    function new();
      debounce    = ctpc_pkg::DEBOUNCE_RST;
      full_scale  = ctpc_pkg::FSCALE_RST;
      menu        = ctpc_pkg::MODE_NORMAL;
      tlim        = ctpc_pkg::TEMP_RST;
      hlim        = ctpc_pkg::HUMI_RST;
      last_press  = '{default: '0};
      heat        = '0;
      fan         = '0;
      pct         = '0;
      fan_running = 1'b0;
      faulted     = 1'b0;
      errors      = 0;
      seen        = 0;
    endfunction

    function void set_reg(ctpc_pkg::cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        ctpc_pkg::REG_DEBOUNCE:   debounce = value;
        ctpc_pkg::REG_FULL_SCALE: full_scale = value;
        default: ;
      endcase
    endfunction

    function void note_item(ctpc_pkg::item_t it);
      ctpc_pkg::result_t r;
      logic [NOW_W-1:0]  since;
      int                t, h, tl, hl, fs, diff, span;
      r  = '0;
      fs = full_scale;
      case (it.cmd)
        ctpc_pkg::CMD_MODE, ctpc_pkg::CMD_UP, ctpc_pkg::CMD_DOWN: begin
          since = it.now_ms - last_press[int'(it.cmd)];
          if (since > debounce) begin
            r.key_accepted = 1'b1;
            last_press[int'(it.cmd)] = it.now_ms;
            if (it.cmd == ctpc_pkg::CMD_MODE) begin
              case (menu)
                ctpc_pkg::MODE_NORMAL: menu = ctpc_pkg::MODE_TEMP;
                ctpc_pkg::MODE_TEMP:   menu = ctpc_pkg::MODE_HUMI;
                ctpc_pkg::MODE_HUMI: begin
                  menu = ctpc_pkg::MODE_NORMAL;
                  r.save_request = 1'b1;
                end
                default:               menu = ctpc_pkg::MODE_NORMAL;
              endcase
            end else if (it.cmd == ctpc_pkg::CMD_UP) begin
              if (menu == ctpc_pkg::MODE_TEMP && tlim < ctpc_pkg::TEMP_MAX) tlim++;
              else if (menu == ctpc_pkg::MODE_HUMI && hlim < ctpc_pkg::HUMI_MAX) hlim++;
            end else begin
              if (menu == ctpc_pkg::MODE_TEMP && tlim > 0) tlim--;
              else if (menu == ctpc_pkg::MODE_HUMI && hlim > 0) hlim--;
            end
          end
        end
        ctpc_pkg::CMD_READ: begin
          if (menu == ctpc_pkg::MODE_NORMAL) begin
            t  = $signed(it.temp_reading);
            h  = it.humi_reading;
            tl = tlim;
            hl = hlim;
            if (t < tl) begin
              diff = tl - t;
              if (diff > tl) diff = tl;
              heat = (tl == 0) ? '0 : DUTY_W'((diff * fs) / tl);
            end else begin
              heat = '0;
            end
            if (h > hl) begin
              span = 100 - hl;
              diff = h - hl;
              if (diff > span) diff = span;
              if (span == 0) begin
                fan = '0;
                pct = '0;
              end else begin
                fan = DUTY_W'((diff * fs) / span);
                pct = PCT_W'((diff * 100) / span);
              end
              fan_running = 1'b1;
            end else begin
              fan         = '0;
              pct         = '0;
              fan_running = 1'b0;
            end
            faulted = 1'b0;
          end
        end
        ctpc_pkg::CMD_FAULT: begin
          if (menu == ctpc_pkg::MODE_NORMAL) begin
            heat        = '0;
            fan         = '0;
            pct         = '0;
            fan_running = 1'b0;
            faulted     = 1'b1;
          end
        end
        default: ;
      endcase
      r.mode         = menu;
      r.temp_limit   = tlim;
      r.humi_limit   = hlim;
      r.heater_duty  = heat;
      r.fan_duty     = fan;
      r.fan_percent  = pct;
      r.fan_on       = fan_running;
      r.sensor_fault = faulted;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("result %0d: %s", seen, msg);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      ctpc_pkg::result_t want;
      int                got_f[FIELD_CNT];
      int                want_f[FIELD_CNT];
      seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item %h", data));
        return;
      end
      want = pending_results.pop_front();
      got_f = '{int'(data[0]), int'(data[2:1]), int'(data[8:3]), int'(data[15:9]),
                int'(data[31:16]), int'(data[47:32]), int'(data[54:48]), int'(data[55]),
                int'(data[56]), int'(data[57]), int'(data[63:58])};
      want_f = '{int'(want.key_accepted), int'(want.mode), int'(want.temp_limit),
                 int'(want.humi_limit), int'(want.heater_duty), int'(want.fan_duty),
                 int'(want.fan_percent), int'(want.fan_on), int'(want.save_request),
                 int'(want.sensor_fault), 0};
      for (int i = 0; i < FIELD_CNT; i++) begin
        if (got_f[i] != want_f[i])
          report($sformatf("%s got %0d expected %0d", field_name[i], got_f[i], want_f[i]));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  climate_result_board board;
  int                  src_idle_pct;
  int                  sink_stall_pct;
  int                  items_sent;
  int                  cycles;
  logic [NOW_W-1:0]    key_time;
  logic [CFG_W-1:0]    key_debounce;

  climate_threshold_pwm_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send(input ctpc_pkg::cmd_t c, input logic [NOW_W-1:0] stamp,
                      input logic [READ_W-1:0] t, input logic [READ_W-1:0] h);
    ctpc_pkg::item_t it;
    it.cmd          = c;
    it.now_ms       = stamp;
    it.temp_reading = t;
    it.humi_reading = h;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {it.humi_reading, it.temp_reading, it.now_ms};
    do @(posedge clk); while (!s_tready);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic press(input ctpc_pkg::cmd_t key, input logic [NOW_W-1:0] stamp);
    send(key, stamp, READ_W'($urandom), READ_W'($urandom));
  endtask

  // mostly clears the lockout, sometimes lands inside it, on its edge or far away
  function automatic logic [NOW_W-1:0] press_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) key_time += key_debounce + 1 + $urandom_range(40);
    else if (pick < 80) key_time += $urandom_range(int'(key_debounce));
    else if (pick < 88) key_time += key_debounce + $urandom_range(1);
    else if (pick < 94) key_time = $urandom;
    return key_time;
  endfunction

  task automatic send_reading();
    int t, h;
    if ($urandom_range(1)) t = $urandom_range(255);
    else t = int'(board.tlim) + int'($urandom_range(6)) - 3;
    if ($urandom_range(1)) h = $urandom_range(255);
    else h = int'(board.hlim) + int'($urandom_range(6)) - 3;
    send(ctpc_pkg::CMD_READ, $urandom, READ_W'(t), READ_W'(h));
  endtask

  task automatic write_config(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] scale);
    cfg_valid <= 1'b1;
    cfg_index <= ctpc_pkg::REG_DEBOUNCE;
    cfg_data  <= debounce;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= ctpc_pkg::REG_FULL_SCALE;
    cfg_data  <= scale;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(ctpc_pkg::REG_DEBOUNCE, debounce);
    board.set_reg(ctpc_pkg::REG_FULL_SCALE, scale);
    key_debounce = debounce;
  endtask

  task automatic run_phase(input int count);
    int             start, pick, len, room;
    ctpc_pkg::cmd_t dir, flip;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // enter the menu, edit both limits, leave with a save
        for (int i = 0; i < 2; i++) begin
          press(ctpc_pkg::CMD_MODE, press_time());
          dir  = $urandom_range(1) ? ctpc_pkg::CMD_UP : ctpc_pkg::CMD_DOWN;
          flip = (dir == ctpc_pkg::CMD_UP) ? ctpc_pkg::CMD_DOWN : ctpc_pkg::CMD_UP;
          len  = ($urandom_range(3) == 0) ? $urandom_range(40, 110) : $urandom_range(1, 10);
          // keep the phase near its item budget
          room = count - (items_sent - start) - 2 + i;
          if (len > room) len = (room > 0) ? room : 0;
          repeat (len) press(($urandom_range(9) < 8) ? dir : flip, press_time());
        end
        press(ctpc_pkg::CMD_MODE, press_time());
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) send_reading();
      end else if (pick < 88) begin
        send(ctpc_pkg::CMD_FAULT, $urandom, READ_W'($urandom), READ_W'($urandom));
      end else begin
        send(ctpc_pkg::cmd_t'($urandom_range(7)), $urandom, READ_W'($urandom),
             READ_W'($urandom));
      end
    end
    s_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  logic [CFG_W-1:0] deb_set[8] = '{16'd0, 16'd65535, 16'd200, 16'd37,
                                   16'd1, 16'd500, 16'd0, 16'd65534};
  logic [CFG_W-1:0] fs_set[8]  = '{16'd1, 16'd65535, 16'd100, 16'd7,
                                   16'd65534, 16'd1000, 16'd3, 16'd40000};

  initial begin
    board          = new();
    cycles         = 0;
    items_sent     = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    key_debounce   = ctpc_pkg::DEBOUNCE_RST;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= ctpc_pkg::REG_DEBOUNCE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // readings at the field extremes and on the limits, then a fault
    send(ctpc_pkg::CMD_READ, 32'h0, 8'h80, 8'd255);
    send(ctpc_pkg::CMD_READ, 32'hFFFF_FFFF, 8'sd127, 8'd0);
    send(ctpc_pkg::CMD_READ, 32'h0, 8'sd20, 8'd60);
    send(ctpc_pkg::CMD_FAULT, 32'h0, 8'sd0, 8'd0);
    // lockout: inside, past, exactly on the window
    press(ctpc_pkg::CMD_UP, 32'd100);
    press(ctpc_pkg::CMD_UP, 32'd201);
    press(ctpc_pkg::CMD_DOWN, 32'd200);
    press(ctpc_pkg::CMD_MODE, 32'hFFFF_FFFF);
    // readings and faults are ignored while editing
    send(ctpc_pkg::CMD_READ, 32'h0, -8'sd5, 8'd99);
    send(ctpc_pkg::CMD_FAULT, 32'h0, 8'sd0, 8'd0);
    press(ctpc_pkg::CMD_UP, 32'h0000_1000);
    press(ctpc_pkg::CMD_DOWN, 32'h0000_2000);
    // timestamp wrap: one ms after the last mode press, then well clear of it
    press(ctpc_pkg::CMD_MODE, 32'h0000_0000);
    press(ctpc_pkg::CMD_MODE, 32'h0000_0100);
    press(ctpc_pkg::CMD_UP, 32'h0000_3000);
    press(ctpc_pkg::CMD_DOWN, 32'h0000_4000);
    send(ctpc_pkg::cmd_t'(3'd5), $urandom, READ_W'($urandom), READ_W'($urandom));
    send(ctpc_pkg::cmd_t'(3'd6), $urandom, READ_W'($urandom), READ_W'($urandom));
    send(ctpc_pkg::cmd_t'(3'd7), $urandom, READ_W'($urandom), READ_W'($urandom));
    press(ctpc_pkg::CMD_MODE, 32'h0000_5000);
    send(ctpc_pkg::CMD_READ, 32'h0, 8'sd0, 8'd100);
    s_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    key_time = 32'h0001_0000;

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      if (p < 5) write_config(deb_set[p], fs_set[p]);
      else write_config(CFG_W'($urandom_range(2000)), CFG_W'($urandom_range(1, 65535)));
      run_phase(PHASE_ITEMS);
    end

    sink_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ctpc_pkg.sv
hdl/ctpc_div.sv
hdl/ctpc_core.sv
hdl/climate_threshold_pwm_controller.sv
hdl/ctpc_checker.sv
dv/climate_threshold_pwm_controller_tb.sv
